/* design/mbe_pkg.sv */
// Package for the Mandelbrot escape-time pixel block.
// Holds the fixed-point widths, constants, register codes and shared types.
// No dependencies.
`default_nettype none

package mbe_pkg;

    // Fixed-point format and datapath widths.
    localparam int FRAC_BITS  = 28;
    localparam int Z_W        = 33;               // signed z and c operands
    localparam int PROD_W     = 2 * Z_W;          // full signed product
    localparam int SQ_W       = PROD_W - FRAC_BITS; // product back in Q.FRAC_BITS
    localparam int NUM_MUL    = 3;

    // Field and register widths.
    localparam int IDX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int STEP_W     = 31;
    localparam int CNT_W      = 9;
    localparam int GREY_W     = 8;
    localparam int OFF_W      = IDX_W + 3;        // 2*idx - dim, signed
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam int MAX_DIM    = 4096;
    localparam int ITER_LIMIT = 256;
    localparam int GREY_MUL   = 35;

    // Coordinates are clipped to [-4, 4]; the escape radius squared is 4.
    localparam logic signed [PROD_W-1:0] COORD_LIM  = PROD_W'(4) <<< FRAC_BITS;
    localparam logic signed [SQ_W:0]     ESCAPE_LIM = (SQ_W + 1)'(4) <<< FRAC_BITS;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(480);
    localparam logic [STEP_W-1:0] RST_STEP   = STEP_W'(1677722);
    localparam logic [CNT_W-1:0]  RST_MAXIT  = CNT_W'(256);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_PIXEL_STEP     = 2'd2,
        REG_MAX_ITERATIONS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [STEP_W-1:0] pixel_step;
        logic [CNT_W-1:0]  max_iterations;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pix_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] count;
    } core_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_LOAD,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/mbe_mul_unit.sv */
// Shared multiplier set: three signed Z_W x Z_W products, registered.
// Used for the pixel-to-plane mapping and for every iteration of z.
// Depends on mbe_pkg.
`default_nettype none

module mbe_mul_unit
    import mbe_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [Z_W-1:0]    op_a [NUM_MUL],
    input  wire logic signed [Z_W-1:0]    op_b [NUM_MUL],
    output logic signed [PROD_W-1:0]      prod [NUM_MUL]
);

    logic signed [PROD_W-1:0] prod_reg [NUM_MUL];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_MUL; i++)
        begin
            prod_reg[i] <= PROD_W'(op_a[i]) * PROD_W'(op_b[i]);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* design/mbe_core.sv */
// Sequencer and iteration datapath of the escape-time block.
// Maps the pixel to c, then loops z = z*z + c through the shared multipliers.
// Depends on mbe_pkg and mbe_mul_unit.
`default_nettype none

module mbe_core
    import mbe_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire pix_t   pix,
    input  wire cfg_t   cfg,
    input  wire logic   out_free,
    output core_status_t status
);

    state_t state_reg, state_next;

    pix_t                    pix_reg;
    logic signed [Z_W-1:0]   cr_reg, ci_reg;
    logic signed [Z_W-1:0]   zr_reg, zi_reg;
    logic [CNT_W-1:0]        count_reg;

    logic                    map_sel;
    logic signed [Z_W-1:0]   op_a [NUM_MUL];
    logic signed [Z_W-1:0]   op_b [NUM_MUL];
    logic signed [PROD_W-1:0] prod [NUM_MUL];

    logic [DIM_W-1:0]        w_clamp, h_clamp;
    logic signed [OFF_W-1:0] off_re, off_im;
    logic signed [Z_W-1:0]   step_op;
    logic [CNT_W-1:0]        limit;

    logic signed [SQ_W-1:0]  sq_r, sq_i, xy;
    logic signed [SQ_W:0]    nr_w, ni_w, mag;
    logic                    finish;

    // Halve the product (floor) and clip the coordinate to [-4, 4].
    function automatic logic signed [Z_W-1:0] map_coord(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] h;
        logic signed [PROD_W-1:0] c;
        h = p >>> 1;
        if (h > COORD_LIM)
            c = COORD_LIM;
        else if (h < -COORD_LIM)
            c = -COORD_LIM;
        else
            c = h;
        return Z_W'(c);
    endfunction

    // Pixel mapping operands.
    always_comb
    begin
        w_clamp = (cfg.image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
        h_clamp = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
        off_re  = $signed({2'b00, pix_reg.col, 1'b0}) - $signed({2'b00, w_clamp});
        off_im  = $signed({2'b00, pix_reg.row, 1'b0}) - $signed({2'b00, h_clamp});
        step_op = $signed({{(Z_W - STEP_W){1'b0}}, cfg.pixel_step});

        if (cfg.max_iterations == '0)
            limit = CNT_W'(1);
        else if (cfg.max_iterations > CNT_W'(ITER_LIMIT))
            limit = CNT_W'(ITER_LIMIT);
        else
            limit = cfg.max_iterations;
    end

    // Multiplier operand selection.
    always_comb
    begin
        op_a[0] = map_sel ? Z_W'(off_re) : zr_reg;
        op_b[0] = map_sel ? step_op      : zr_reg;
        op_a[1] = map_sel ? Z_W'(off_im) : zi_reg;
        op_b[1] = map_sel ? step_op      : zi_reg;
        op_a[2] = zr_reg;
        op_b[2] = zi_reg;
    end

    mbe_mul_unit u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // One pass of the update and the escape test on the registered products.
    always_comb
    begin
        sq_r   = SQ_W'(prod[0] >>> FRAC_BITS);
        sq_i   = SQ_W'(prod[1] >>> FRAC_BITS);
        xy     = SQ_W'(prod[2] >>> FRAC_BITS);
        nr_w   = (SQ_W + 1)'(sq_r) - (SQ_W + 1)'(sq_i) + (SQ_W + 1)'(cr_reg);
        ni_w   = ((SQ_W + 1)'(xy) <<< 1) + (SQ_W + 1)'(ci_reg);
        mag    = (SQ_W + 1)'(sq_r) + (SQ_W + 1)'(sq_i);
        // The products describe the z left by count_reg passes; with no pass
        // made yet there is nothing to test.
        finish = (count_reg != '0) && ((mag >= ESCAPE_LIM) || (count_reg >= limit));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MAP;
            ST_MAP:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL:  state_next = ST_STEP;
            ST_STEP: state_next = finish ? ST_DONE : ST_MUL;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        map_sel      = 1'b0;
        status.idle  = 1'b0;
        status.done  = 1'b0;
        status.count = count_reg;
        unique case (state_reg)
            ST_IDLE: status.idle = 1'b1;
            ST_MAP:  map_sel = 1'b1;
            ST_DONE: status.done = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
                count_reg <= '0;
            else if (state_reg == ST_STEP && !finish)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            pix_reg <= pix;
        if (state_reg == ST_LOAD)
        begin
            cr_reg <= map_coord(prod[0]);
            ci_reg <= map_coord(prod[1]);
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (state_reg == ST_STEP && !finish)
        begin
            zr_reg <= Z_W'(nr_w);
            zi_reg <= Z_W'(ni_w);
        end
    end

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time_pixel.sv */
// Top level of the Mandelbrot escape-time pixel block.
// Holds the configuration registers and the result register around mbe_core.
// Depends on mbe_pkg, mbe_core and mbe_mul_unit.
//
// Channel   Direction  Handshake                   Content
// s_axis    in         s_axis_tvalid/tready        pixel row and column
// m_axis    out        m_axis_tvalid/tready        iteration count and grey level
// cfg       in         cfg_wr_en (no wait)         register index and write data
//
// An item passes from acceptance through the mapping states (ST_MAP, ST_LOAD), a
// multiply/update loop (ST_MUL, ST_STEP) that runs N + 1 times, N being the passes
// (1 to 256), and the hand-off state (ST_DONE) on its way to the result register.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// idles the sequencer. s_axis_tready is high only while the sequencer is idle;
// a finished item waits in the core while the result register is still full.
`default_nettype none

module mandelbrot_escape_time_pixel
    import mbe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,   // [11:0] pixel_row, [23:12] pixel_col

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // [8:0] iteration_count,
                                                       // [16:9] grey_level, rest zero

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg_reg, cfg_next;
    pix_t         pix;
    core_status_t status;
    logic         start;
    logic         out_free;

    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  m_count_reg;
    logic [GREY_W-1:0] m_grey_reg;

    // Configuration writes; each register keeps its own width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_IMAGE_WIDTH:    cfg_next.image_width    = cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   cfg_next.image_height   = cfg_wdata[DIM_W-1:0];
                REG_PIXEL_STEP:     cfg_next.pixel_step     = cfg_wdata[STEP_W-1:0];
                REG_MAX_ITERATIONS: cfg_next.max_iterations = cfg_wdata[CNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= RST_WIDTH;
            cfg_reg.image_height   <= RST_HEIGHT;
            cfg_reg.pixel_step     <= RST_STEP;
            cfg_reg.max_iterations <= RST_MAXIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side: an item is taken only while the sequencer is idle.
    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign pix.row       = s_axis_tdata[IDX_W-1:0];
    assign pix.col       = s_axis_tdata[2*IDX_W-1:IDX_W];

    // The core hands over its count only when the result register can take it.
    assign out_free = !m_valid_reg || m_axis_tready;

    mbe_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .pix      (pix),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .status   (status)
    );

    // Result register.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (status.done)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            m_count_reg <= status.count;
            // Only the low byte of the count matters for the grey level.
            m_grey_reg  <= GREY_W'(status.count[GREY_W-1:0] * GREY_W'(GREY_MUL));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(24 - CNT_W - GREY_W)'(0), m_grey_reg, m_count_reg};

    // The core never hands over a result while the result register is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (!m_valid_reg || m_axis_tready))
        else $error("result handed over while output register is occupied");

    // Every delivered count lies between one pass and the hard limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (status.count != '0 && status.count <= CNT_W'(ITER_LIMIT)))
        else $error("iteration count out of range");

    // After taking an item the block is busy until that item is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // A finished item returns the sequencer to idle in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> s_axis_tready)
        else $error("sequencer did not return to idle after hand-over");

endmodule

`default_nettype wire
